// ===== hw/rtl/utf8_to_utf16_decoder_top_macros.svh =====
// Assertion macros shared by the UTF-8 to UTF-16 decoder RTL
`ifndef UTF8_TO_UTF16_DECODER_TOP_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define U8U_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define U8U_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define U8U_ASSERT(lbl, clk, rstn, prop, msg)
`define U8U_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/u8u16_pkg.sv =====
// Types and constants for the UTF-8 to UTF-16 decoder
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CAP_W           = 16;
    localparam int UNIT_W          = 16;
    localparam int BYTE_W          = 8;
    localparam int OFIFO_DEPTH     = 4;
    localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_FULL     = 2'd2,
        ST_TRUNC    = 2'd3
    } status_t;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              end_of_string;
        status_t           status;
    } result_t;

    // up to two results per byte, r0 first
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

// ===== hw/rtl/u8u16_decode.sv =====
// Input register, string state and single-pass byte decode
`timescale 1ns / 1ps
`include "utf8_to_utf16_decoder_top_macros.svh"

module u8u16_decode #(
    parameter int COUNT_WIDTH = u8u16_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [u8u16_pkg::BYTE_W-1:0]        s_tdata,
    input  logic                                s_tlast,
    input  logic                                cfg_valid,
    input  logic [u8u16_pkg::CAP_W-1:0]         cfg_data,
    input  logic                                room,
    output u8u16_pkg::push_t                    push
);

    localparam int SUM_W =
        ((COUNT_WIDTH > u8u16_pkg::CAP_W) ? COUNT_WIDTH : u8u16_pkg::CAP_W) + 1;

    logic                               in_valid_reg, in_valid_next;
    logic [u8u16_pkg::BYTE_W-1:0]       in_byte_reg;
    logic                               in_last_reg;
    logic [u8u16_pkg::CAP_W-1:0]        cap_reg;
    logic [1:0]                         pend_reg, pend_next;
    logic [u8u16_pkg::UNIT_W-1:0]       acc_reg, acc_next;
    logic [COUNT_WIDTH-1:0]             uw_reg, uw_next;
    logic                               halted_reg, halted_next;

    logic                               fire;
    logic                               load;
    logic                               uw_sat;
    logic                               cap_hit;
    logic [SUM_W-1:0]                   uw_sum;
    logic [COUNT_WIDTH-1:0]             uw_inc;
    logic [u8u16_pkg::UNIT_W-1:0]       acc_merge;
    u8u16_pkg::result_t                 term;

    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;
    assign load     = s_tvalid && s_tready;

    assign uw_sat    = (uw_reg == {COUNT_WIDTH{1'b1}});
    assign uw_inc    = uw_sat ? uw_reg : uw_reg + 1'b1;
    assign uw_sum    = SUM_W'(uw_reg) + 1'b1;
    assign cap_hit   = (uw_sum >= SUM_W'(cap_reg)) || uw_sat;
    assign acc_merge = {acc_reg[u8u16_pkg::UNIT_W-7:0], in_byte_reg[5:0]};

    always_comb begin
        in_valid_next = load ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        pend_next     = pend_reg;
        acc_next      = acc_reg;
        uw_next       = uw_reg;
        halted_next   = halted_reg;
        push          = '0;
        term          = '0;
        term.end_of_string = 1'b1;

        if (fire) begin
            if (halted_reg) begin
                // swallow
            end else if (pend_reg != 2'd0) begin
                pend_next = pend_reg - 2'd1;
                if (pend_reg == 2'd1) begin
                    push.r0.code_unit = acc_merge;
                    push.n            = 2'd1;
                    uw_next           = uw_inc;
                    acc_next          = '0;
                end else begin
                    acc_next = acc_merge;
                end
            end else if (cap_hit) begin
                push.r0        = term;
                push.r0.status = u8u16_pkg::ST_FULL;
                push.n         = 2'd1;
                halted_next    = 1'b1;
            end else if (!in_byte_reg[7]) begin
                push.r0.code_unit = {{(u8u16_pkg::UNIT_W-u8u16_pkg::BYTE_W){1'b0}}, in_byte_reg};
                push.n            = 2'd1;
                uw_next           = uw_inc;
            end else if (in_byte_reg[7:5] == 3'b110) begin
                acc_next  = {{(u8u16_pkg::UNIT_W-5){1'b0}}, in_byte_reg[4:0]};
                pend_next = 2'd1;
            end else if (in_byte_reg[7:4] == 4'b1110) begin
                acc_next  = {{(u8u16_pkg::UNIT_W-4){1'b0}}, in_byte_reg[3:0]};
                pend_next = 2'd2;
            end else begin
                push.r0        = term;
                push.r0.status = u8u16_pkg::ST_BAD_LEAD;
                push.n         = 2'd1;
                halted_next    = 1'b1;
            end

            if (in_last_reg) begin
                if (!halted_next) begin
                    term.status = (pend_next != 2'd0) ? u8u16_pkg::ST_TRUNC
                                                      : u8u16_pkg::ST_OK;
                    if (push.n == 2'd0) begin
                        push.r0 = term;
                    end else begin
                        push.r1 = term;
                    end
                    push.n = push.n + 2'd1;
                end
                pend_next   = '0;
                acc_next    = '0;
                uw_next     = '0;
                halted_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            cap_reg      <= u8u16_pkg::CAP_RESET;
            pend_reg     <= '0;
            acc_reg      <= '0;
            uw_reg       <= '0;
            halted_reg   <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            pend_reg     <= pend_next;
            acc_reg      <= acc_next;
            uw_reg       <= uw_next;
            halted_reg   <= halted_next;
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    `U8U_ASSERT(a_halt_no_pend, aclk, aresetn, halted_reg |-> (pend_reg == 2'd0), "pending bytes while halted")
    `U8U_ASSERT(a_eos_clears, aclk, aresetn, (fire && in_last_reg) |=> (pend_reg == 2'd0 && uw_reg == '0 && !halted_reg), "state not cleared at end of string")
    `U8U_ASSERT(a_halt_silent, aclk, aresetn, (fire && halted_reg) |-> (push.n == 2'd0), "result while halted")
    `U8U_ASSERT(a_push_max, aclk, aresetn, push.n != 2'd3, "more than two results for one byte")

endmodule

// ===== hw/rtl/u8u16_ofifo.sv =====
// Result queue: takes up to two results a cycle, hands out one
`timescale 1ns / 1ps
`include "utf8_to_utf16_decoder_top_macros.svh"

module u8u16_ofifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  u8u16_pkg::push_t     push,
    output logic                 room,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output u8u16_pkg::result_t   head
);

    localparam int DEPTH = u8u16_pkg::OFIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    u8u16_pkg::result_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [PTR_W-1:0]     wr_ptr_p1;
    logic                 pop;

    assign pop       = m_tvalid && m_tready;
    assign m_tvalid  = (count_reg != '0);
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign head      = mem_reg[rd_ptr_reg];
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.n);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.n) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem_reg[wr_ptr_p1] <= push.r1;
        end
    end

    `U8U_ASSERT(a_no_overflow, aclk, aresetn, count_reg <= CNT_W'(DEPTH), "result queue overflow")
    `U8U_ASSERT(a_push_room, aclk, aresetn, (push.n != 2'd0) |-> room, "push without room")
    `U8U_ASSERT(a_pop_only, aclk, aresetn, (pop && push.n == 2'd0) |=> (count_reg == $past(count_reg) - 1'b1), "bad count after pop")

endmodule

// ===== hw/rtl/utf8_to_utf16_decoder_top.sv =====
// A byte's results pass through the input register and then the result queue before they appear.
// Throughput: one byte per cycle while the result queue has room; a byte giving two results queues both at once.
// The 4-entry result queue sets how far output stalls can be absorbed before s_tready drops.
// Reset: synchronous, active low; clears string state, queue, and sets out_capacity to 256.
// Configuration writes are always taken (cfg_ready tied high).
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_top #(
    parameter int COUNT_WIDTH = u8u16_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [u8u16_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] in_byte
    input  logic                               s_tlast,   // last_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [u8u16_pkg::UNIT_W-1:0]       m_tdata,   // [15:0] code_unit
    output logic                               m_tlast,   // end_of_string
    output logic [1:0]                         m_tuser,   // [1:0] status
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [u8u16_pkg::CAP_W-1:0]        cfg_data   // out_capacity
);

    u8u16_pkg::push_t    push;
    u8u16_pkg::result_t  head;
    logic                room;

    assign cfg_ready = 1'b1;

    u8u16_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .room      (room),
        .push      (push)
    );

    u8u16_ofifo u_ofifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign m_tdata = head.code_unit;
    assign m_tlast = head.end_of_string;
    assign m_tuser = head.status;

endmodule

// ===== dv/utf8_to_utf16_decoder_checker.sv =====
// Checker for the UTF-8 to UTF-16 decoder: predicts each string's code units, end flags and statuses and compares them
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_checker #(
    parameter int COUNT_WIDTH = u8u16_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [u8u16_pkg::BYTE_W-1:0] s_tdata,
    input  logic                         s_tlast,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [u8u16_pkg::UNIT_W-1:0] m_tdata,
    input  logic                         m_tlast,
    input  logic [1:0]                   m_tuser,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [u8u16_pkg::CAP_W-1:0]  cfg_data,
    output int                           mismatch_count,
    output int                           outstanding
);
    import u8u16_pkg::*;

    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;

    result_t                expected_units[$];
    logic [1:0]             cont_left;
    logic [UNIT_W-1:0]      unit_acc;
    logic [COUNT_WIDTH-1:0] units_out;
    logic                   string_halted;
    logic [CAP_W-1:0]       capacity;
    int                     errors = 0;

    task automatic expect_unit(input logic [UNIT_W-1:0] unit, input logic eos,
                               input status_t st);
        result_t r;
        r.code_unit     = unit;
        r.end_of_string = eos;
        r.status        = st;
        expected_units.push_back(r);
    endtask

    task automatic clear_string;
        cont_left     = 2'd0;
        unit_acc      = '0;
        units_out     = '0;
        string_halted = 1'b0;
    endtask

    task automatic count_unit;
        longint unsigned w;
        w = units_out;
        if (w < COUNT_MAX)
            units_out = units_out + 1'b1;
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
        longint unsigned w;
        longint unsigned cap;
        w   = units_out;
        cap = capacity;
        if (string_halted) begin
            if (last)
                clear_string();
            return;
        end
        if (cont_left != 2'd0) begin
            unit_acc  = {unit_acc[UNIT_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                expect_unit(unit_acc, 1'b0, ST_OK);
                count_unit();
                unit_acc = '0;
            end
        end else if (w + 1 >= cap || w == COUNT_MAX) begin
            expect_unit('0, 1'b1, ST_FULL);
            string_halted = 1'b1;
        end else if (b <= 8'h7f) begin
            expect_unit({8'h00, b}, 1'b0, ST_OK);
            count_unit();
        end else if (b >= 8'hc0 && b <= 8'hdf) begin
            unit_acc  = {11'd0, b[4:0]};
            cont_left = 2'd1;
        end else if (b >= 8'he0 && b <= 8'hef) begin
            unit_acc  = {12'd0, b[3:0]};
            cont_left = 2'd2;
        end else begin
            expect_unit('0, 1'b1, ST_BAD_LEAD);
            string_halted = 1'b1;
        end
        if (last) begin
            if (!string_halted)
                expect_unit('0, 1'b1, (cont_left != 2'd0) ? ST_TRUNC : ST_OK);
            clear_string();
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            clear_string();
            capacity = CAP_RESET;
            expected_units.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_units.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected word unit=%h eos=%b status=%0d",
                                 $realtime, m_tdata, m_tlast, m_tuser);
                end else begin
                    want = expected_units.pop_front();
                    if (m_tdata !== want.code_unit || m_tlast !== want.end_of_string ||
                        m_tuser !== want.status) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch exp unit=%h eos=%b status=%0d, got unit=%h eos=%b status=%0d",
                                     $realtime, want.code_unit, want.end_of_string,
                                     want.status, m_tdata, m_tlast, m_tuser);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
        end
        mismatch_count <= errors;
        outstanding    <= expected_units.size();
    end

endmodule

// ===== dv/tb_utf8_to_utf16_decoder_top.sv =====
// Testbench top for the UTF-8 to UTF-16 decoder: clock, reset, byte strings, stalls and verdict
`timescale 1ns / 1ps

module tb_utf8_to_utf16_decoder_top;
    import u8u16_pkg::*;

    localparam int ITEM_TARGET = 1100;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic [BYTE_W-1:0]   s_tdata   = '0;
    logic                s_tlast   = 1'b0;
    logic                m_tready  = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [CAP_W-1:0]    cfg_data  = '0;
    logic                s_tready;
    logic                m_tvalid;
    logic [UNIT_W-1:0]   m_tdata;
    logic                m_tlast;
    logic [1:0]          m_tuser;
    logic                cfg_ready;
    int                  mismatch_count;
    int                  outstanding;

    int                  burst_left = 0;
    int                  bytes_sent = 0;
    int                  rx_mode    = 0;
    int                  rx_left    = 0;
    logic [BYTE_W-1:0]   str_bytes[$];

    always #10 aclk = ~aclk;

    utf8_to_utf16_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    utf8_to_utf16_decoder_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // receiver: runs of always-ready, coin-flip and heavy back-pressure
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(8, 64);
        end
        rx_left--;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // hold off until every expected word has come, then let the pipeline settle
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_cont;
        if ($urandom_range(0, 7) == 0)
            str_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
        else
            str_bytes.push_back(BYTE_W'($urandom_range(8'h80, 8'hbf)));
    endtask

    task automatic build_string(input int max_chars);
        int n;
        int kind;
        int k;
        n    = $urandom_range(1, max_chars);
        kind = $urandom_range(0, 9);
        str_bytes.delete();
        if (kind == 9) begin
            // noise
            for (k = 0; k < n; k++)
                str_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
        end else begin
            for (k = 0; k < n; k++) begin
                case ($urandom_range(0, 2))
                    0: str_bytes.push_back(BYTE_W'($urandom_range(0, 8'h7f)));
                    1: begin
                        str_bytes.push_back(BYTE_W'($urandom_range(8'hc0, 8'hdf)));
                        push_cont();
                    end
                    default: begin
                        str_bytes.push_back(BYTE_W'($urandom_range(8'he0, 8'hef)));
                        push_cont();
                        push_cont();
                    end
                endcase
            end
            if (kind == 8) begin
                if ($urandom_range(0, 1) == 0) begin
                    str_bytes.insert($urandom_range(0, str_bytes.size()),
                                     BYTE_W'(($urandom_range(0, 1) == 0) ?
                                             $urandom_range(8'h80, 8'hbf) :
                                             $urandom_range(8'hf0, 8'hff)));
                end else begin
                    // cut off mid-sequence
                    str_bytes.push_back(BYTE_W'($urandom_range(8'hc0, 8'hef)));
                    if (str_bytes[str_bytes.size() - 1] >= 8'he0 && $urandom_range(0, 1) == 0)
                        push_cont();
                end
            end
        end
    endtask

    task automatic send_string;
        foreach (str_bytes[i])
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
    endtask

    initial begin
        int phase;
        int strings_left;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset capacity of 256 in force
        send_byte(8'h00, 1'b1);
        send_byte(8'h7f, 1'b1);
        send_byte(8'hc0, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hdf, 1'b0);
        send_byte(8'hbf, 1'b1);
        send_byte(8'he0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hef, 1'b0);
        send_byte(8'hbf, 1'b0);
        send_byte(8'hbf, 1'b1);
        // bad lead, then swallowed bytes up to the end of the string
        send_byte(8'h41, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(8'hff, 1'b1);
        // truncated sequences, then a complete two-byte sequence
        send_byte(8'hc3, 1'b1);
        send_byte(8'he2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hc3, 1'b0);
        send_byte(8'ha9, 1'b0);
        send_byte(8'h41, 1'b1);
        // destination full
        set_capacity(16'd1);
        send_byte(8'h41, 1'b1);
        set_capacity(16'd2);
        send_byte(8'h61, 1'b0);
        send_byte(8'hc3, 1'b0);
        send_byte(8'ha9, 1'b1);

        phase        = 0;
        strings_left = 0;
        while (bytes_sent < ITEM_TARGET) begin
            if (strings_left == 0) begin
                case (phase % 6)
                    0:       set_capacity(CAP_W'($urandom_range(2, 6)));
                    1:       set_capacity(16'hffff);
                    2:       set_capacity(CAP_W'($urandom_range(7, 40)));
                    3:       set_capacity(16'd1);
                    4:       set_capacity(CAP_RESET);
                    default: set_capacity(16'd2);
                endcase
                phase++;
                strings_left = 15;
            end
            build_string(($urandom_range(0, 15) == 0) ? 40 : 10);
            send_string();
            strings_left--;
            if ($urandom_range(0, 29) == 0)
                drain();
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("utf8_to_utf16_decoder_top verification clean");
        else
            $display("utf8_to_utf16_decoder_top verification failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("utf8_to_utf16_decoder_top verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/u8u16_pkg.sv
hw/rtl/u8u16_decode.sv
hw/rtl/u8u16_ofifo.sv
hw/rtl/utf8_to_utf16_decoder_top.sv
dv/utf8_to_utf16_decoder_checker.sv
dv/tb_utf8_to_utf16_decoder_top.sv
